@@ hdl/dsvm_pkg.sv @@
package dsvm_pkg;

  localparam logic [2:0] REQ_TICK     = 3'd0;
  localparam logic [2:0] REQ_LOAD     = 3'd1;
  localparam logic [2:0] REQ_REGION   = 3'd2;
  localparam logic [2:0] REQ_PEND_END = 3'd3;
  localparam logic [2:0] REQ_INC      = 3'd4;
  localparam logic [2:0] REQ_TRIGGER  = 3'd5;

  localparam int MIX_BITS = 14;  // 16 voices * 2 copies * 128 fits signed 14 bits

  localparam logic signed [MIX_BITS-1:0] MIX_MAX      = 14'sd127;
  localparam logic signed [MIX_BITS-1:0] MIX_MIN      = -14'sd128;
  localparam logic [7:0]                 LEVEL_MAX    = 8'd255;
  localparam logic [7:0]                 LEVEL_MIN    = 8'd0;
  localparam logic [7:0]                 LEVEL_OFFSET = 8'd128;
  localparam int                         MASK_BITS    = 8;

  typedef struct packed {
    logic [2:0]        req_type;
    logic [2:0]        voice;
    logic [13:0]       wave_index;
    logic signed [7:0] wave_byte;
    logic [13:0]       start_index;
    logic [13:0]       end_index;
    logic [3:0]        step_inc;
    logic [2:0]        shift_big;
    logic [2:0]        shift_small;
  } in_item_t;

  typedef struct packed {
    logic [7:0] pwm_level;
    logic [7:0] active_mask;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_ACCUM,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic apply;
    logic clear;
    logic fetch;
    logic accum;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } ctrl_status_t;

  function automatic logic signed [MIX_BITS-1:0] sar_ext(logic signed [7:0] s,
                                                         logic [2:0] k);
    logic signed [7:0] r;
    r = s >>> k;
    return MIX_BITS'(r);
  endfunction

endpackage

@@ hdl/drum_sample_voice_mixer.sv @@
// Tick transfer: each voice passes through a wave memory read state and then an
// accumulate state; the result register then loads in the finish state once the output
// register is free, and the next input is taken in the cycle after that.
// Load, region, pending end, increment and trigger transfers are applied in the idle state.
// Synchronous reset: voices idle, regions and shifts zero, increments four;
// wave memory holds no defined value until loaded.
module drum_sample_voice_mixer #(
  parameter int VOICE_COUNT    = 8,
  parameter int WAVE_ADDR_BITS = 14,
  parameter int FRAC_BITS      = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  dsvm_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output dsvm_pkg::out_item_t out_item
);
  import dsvm_pkg::*;

  localparam int VIDX_BITS = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;

  ctrl_cmd_t            cmd;
  ctrl_status_t         status;
  logic [VIDX_BITS-1:0] idx;

  dsvm_ctrl #(
    .VOICE_COUNT(VOICE_COUNT),
    .VIDX_BITS  (VIDX_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .req_type(in_item.req_type),
    .in_stall(in_stall),
    .cmd     (cmd),
    .idx     (idx),
    .status  (status)
  );

  dsvm_datapath #(
    .VOICE_COUNT   (VOICE_COUNT),
    .WAVE_ADDR_BITS(WAVE_ADDR_BITS),
    .FRAC_BITS     (FRAC_BITS),
    .VIDX_BITS     (VIDX_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .cmd      (cmd),
    .idx      (idx),
    .status   (status),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

endmodule

@@ hdl/dsvm_ctrl.sv @@
module dsvm_ctrl #(
  parameter int VOICE_COUNT = 8,
  parameter int VIDX_BITS   = 3
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [2:0]              req_type,
  output logic                    in_stall,
  output dsvm_pkg::ctrl_cmd_t     cmd,
  output logic [VIDX_BITS-1:0]    idx,
  input  dsvm_pkg::ctrl_status_t  status
);
  import dsvm_pkg::*;

  state_t               state;
  state_t               state_next;
  logic [VIDX_BITS-1:0] idx_next;
  logic                 last;

  assign last = (idx == VIDX_BITS'(VOICE_COUNT - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    unique case (state)
      ST_IDLE: begin
        idx_next = '0;
        if (in_valid && req_type == REQ_TICK) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        if (last) begin
          state_next = ST_FINISH;
        end else begin
          state_next = ST_FETCH;
          idx_next   = idx + 1'b1;
        end
      end
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.apply  = in_valid && (req_type != REQ_TICK);
        cmd.clear  = in_valid && (req_type == REQ_TICK);
      end
      ST_FETCH:  cmd.fetch  = 1'b1;
      ST_ACCUM:  cmd.accum  = 1'b1;
      ST_FINISH: cmd.finish = status.out_free;
      default:   cmd = '0;
    endcase
  end

`ifndef SYNTH
  a_tick_starts_at_voice_zero: assert property (@(posedge clk) disable iff (rst)
    cmd.clear |=> (state == ST_FETCH) && (idx == '0))
    else $error("tick did not start at voice zero");

  a_finish_only_when_free: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> status.out_free)
    else $error("result loaded while output register busy");

  a_voice_advance: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ACCUM) && !last |=> (state == ST_FETCH) && (idx == $past(idx) + 1'b1))
    else $error("voice counter did not advance");
`endif

endmodule

@@ hdl/dsvm_datapath.sv @@
module dsvm_datapath #(
  parameter int VOICE_COUNT    = 8,
  parameter int WAVE_ADDR_BITS = 14,
  parameter int FRAC_BITS      = 2,
  parameter int VIDX_BITS      = 3
) (
  input  logic                    clk,
  input  logic                    rst,
  input  dsvm_pkg::in_item_t      in_item,
  input  dsvm_pkg::ctrl_cmd_t     cmd,
  input  logic [VIDX_BITS-1:0]    idx,
  output dsvm_pkg::ctrl_status_t  status,
  output logic                    out_valid,
  input  logic                    out_stall,
  output dsvm_pkg::out_item_t     out_item
);
  import dsvm_pkg::*;

  localparam int WAVE_DEPTH = 1 << WAVE_ADDR_BITS;
  localparam int END_BITS   = WAVE_ADDR_BITS + FRAC_BITS;
  localparam int POS_BITS   = END_BITS + 1;

  logic [7:0] wave_mem [WAVE_DEPTH];
  logic signed [7:0] rd_byte;

  logic [POS_BITS-1:0] play_pos  [VOICE_COUNT];
  logic [END_BITS-1:0] start_pos [VOICE_COUNT];
  logic [END_BITS-1:0] end_pos   [VOICE_COUNT];
  logic [END_BITS-1:0] pend_end  [VOICE_COUNT];
  logic                pend_valid [VOICE_COUNT];
  logic [3:0]          inc       [VOICE_COUNT];
  logic [2:0]          big_sh    [VOICE_COUNT];
  logic [2:0]          small_sh  [VOICE_COUNT];

  logic signed [MIX_BITS-1:0] mix;
  logic [MASK_BITS-1:0]       mask;
  logic                       playing;

  logic [VIDX_BITS-1:0]      wv;
  logic                      voice_ok;
  logic [WAVE_ADDR_BITS-1:0] load_addr;
  logic [WAVE_ADDR_BITS-1:0] rd_addr;
  logic [END_BITS-1:0]       start_q;
  logic [END_BITS-1:0]       end_q;
  logic                      take_pend;
  logic [END_BITS-1:0]       end_eff;
  logic signed [MIX_BITS-1:0] contrib;
  logic [7:0]                level;

  assign wv        = VIDX_BITS'(in_item.voice);
  assign voice_ok  = 32'(in_item.voice) < VOICE_COUNT;
  assign load_addr = WAVE_ADDR_BITS'(in_item.wave_index);
  assign start_q   = END_BITS'(WAVE_ADDR_BITS'(in_item.start_index)) << FRAC_BITS;
  assign end_q     = END_BITS'(WAVE_ADDR_BITS'(in_item.end_index)) << FRAC_BITS;
  assign rd_addr   = play_pos[idx][FRAC_BITS +: WAVE_ADDR_BITS];
  assign take_pend = pend_valid[idx] && (play_pos[idx] == {1'b0, start_pos[idx]});
  assign end_eff   = take_pend ? pend_end[idx] : end_pos[idx];
  assign contrib   = sar_ext(rd_byte, big_sh[idx]) + sar_ext(rd_byte, small_sh[idx]);

  always_ff @(posedge clk) begin
    if (cmd.apply && in_item.req_type == REQ_LOAD) begin
      wave_mem[load_addr] <= in_item.wave_byte;
    end
    if (cmd.fetch) begin
      rd_byte <= wave_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VOICE_COUNT; i++) begin
        play_pos[i]   <= '1;
        start_pos[i]  <= '0;
        end_pos[i]    <= '0;
        pend_end[i]   <= '0;
        pend_valid[i] <= 1'b0;
        inc[i]        <= 4'd4;
        big_sh[i]     <= '0;
        small_sh[i]   <= '0;
      end
    end else if (cmd.apply) begin
      if (voice_ok) begin
        unique case (in_item.req_type)
          REQ_REGION: begin
            start_pos[wv] <= start_q;
            end_pos[wv]   <= end_q;
          end
          REQ_PEND_END: begin
            pend_end[wv]   <= end_q;
            pend_valid[wv] <= 1'b1;
          end
          REQ_INC: inc[wv] <= in_item.step_inc;
          REQ_TRIGGER: begin
            big_sh[wv]   <= in_item.shift_big;
            small_sh[wv] <= in_item.shift_small;
            play_pos[wv] <= {1'b0, start_pos[wv]};
          end
          default: ;
        endcase
      end
    end else if (cmd.fetch) begin
      if (take_pend) begin
        end_pos[idx]    <= pend_end[idx];
        pend_valid[idx] <= 1'b0;
      end
    end else if (cmd.accum && playing) begin
      play_pos[idx] <= play_pos[idx] + POS_BITS'(inc[idx]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      mix  <= '0;
      mask <= '0;
    end else if (cmd.fetch) begin
      playing <= play_pos[idx] <= {1'b0, end_eff};
    end else if (cmd.accum && playing) begin
      mix <= mix + contrib;
      if (32'(idx) < MASK_BITS) begin
        mask <= mask | (MASK_BITS'(1) << idx);
      end
    end
  end

  always_comb begin
    if (mix > MIX_MAX) begin
      level = LEVEL_MAX;
    end else if (mix < MIX_MIN) begin
      level = LEVEL_MIN;
    end else begin
      level = mix[7:0] ^ LEVEL_OFFSET;
    end
  end

  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_item.pwm_level   <= level;
      out_item.active_mask <= mask;
    end
  end

`ifndef SYNTH
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.apply, cmd.clear, cmd.fetch, cmd.accum, cmd.finish}))
    else $error("more than one datapath command");

  a_accum_after_fetch: assert property (@(posedge clk) disable iff (rst)
    cmd.accum |-> $past(cmd.fetch))
    else $error("accumulate without a memory read");

  a_finish_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> out_valid)
    else $error("result not presented after finish");
`endif

endmodule

@@ tb/drum_sample_voice_mixer_test.sv @@
module drum_sample_voice_mixer_test;
  import dsvm_pkg::*;

  localparam int VOICES = 8;
  localparam int WAVE_DEPTH = 16384;
  localparam int LIMIT = 600000;
  localparam int RANDOM_ITEMS = 950;
  localparam int SETTLE = 2 * VOICES + 12;
  localparam logic [2:0] REQ_SPARE_A = 3'd6;
  localparam logic [2:0] REQ_SPARE_B = 3'd7;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t want;
  } script_row_t;

  logic      clk;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;

  // voice and wave memory shadow
  logic signed [7:0] wave_mem [WAVE_DEPTH];
  bit                wave_known [WAVE_DEPTH];
  logic [16:0]       voice_pos [VOICES];
  logic [15:0]       voice_start [VOICES];
  logic [15:0]       voice_end [VOICES];
  logic [15:0]       voice_pend [VOICES];
  bit                voice_pend_ok [VOICES];
  logic [3:0]        voice_inc [VOICES];
  logic [2:0]        voice_big [VOICES];
  logic [2:0]        voice_small [VOICES];

  out_item_t   mix_expected [$];
  script_row_t script [$];
  out_item_t   head;
  bit          calm = 1'b0;
  int          n_cycles = 0;
  int          n_items = 0;
  int          n_ticks = 0;
  int          n_fixups = 0;
  int          n_checked = 0;
  int          n_bad = 0;

  drum_sample_voice_mixer dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) n_cycles <= n_cycles + 1;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(99) < 31);
    end
  end

  function automatic void note_mismatch(input string what, input int want, input int got);
    n_bad++;
    if (n_bad <= 10) begin
      $display("mismatch %s at cycle %0d: expected %0d, got %0d", what, n_cycles, want, got);
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (mix_expected.size() == 0) begin
        note_mismatch("unexpected transfer", -1, out_item.pwm_level);
      end else begin
        head = mix_expected.pop_front();
        n_checked++;
        if (out_item.pwm_level !== head.pwm_level) begin
          note_mismatch("pwm_level", head.pwm_level, out_item.pwm_level);
        end
        if (out_item.active_mask !== head.active_mask) begin
          note_mismatch("active_mask", head.active_mask, out_item.active_mask);
        end
      end
    end
  end

  initial begin
    while (n_cycles < LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding", n_cycles, mix_expected.size());
    $display("drum_sample_voice_mixer_test: errors");
    $finish;
  end

  // Advance the shadow by one accepted item; returns 1 when a tick yields a level.
  function automatic bit model_step(input in_item_t it, output out_item_t res);
    int i;
    int mix;
    logic signed [7:0] smp;
    res = '0;
    case (it.req_type)
      REQ_TICK: begin
        mix = 0;
        for (i = 0; i < VOICES; i++) begin
          if (voice_pend_ok[i] && voice_pos[i] == {1'b0, voice_start[i]}) begin
            voice_end[i] = voice_pend[i];
            voice_pend_ok[i] = 1'b0;
          end
          if (voice_pos[i] <= {1'b0, voice_end[i]}) begin
            smp = wave_mem[voice_pos[i][15:2]];
            mix += int'(smp >>> voice_big[i]) + int'(smp >>> voice_small[i]);
            voice_pos[i] = voice_pos[i] + voice_inc[i];
            res.active_mask[i] = 1'b1;
          end
        end
        if (mix > int'(MIX_MAX)) res.pwm_level = LEVEL_MAX;
        else if (mix < int'(MIX_MIN)) res.pwm_level = LEVEL_MIN;
        else res.pwm_level = 8'(mix + int'(LEVEL_OFFSET));
        return 1'b1;
      end
      REQ_LOAD: begin
        wave_mem[it.wave_index] = it.wave_byte;
        wave_known[it.wave_index] = 1'b1;
      end
      REQ_REGION: begin
        voice_start[it.voice] = {it.start_index, 2'b00};
        voice_end[it.voice] = {it.end_index, 2'b00};
      end
      REQ_PEND_END: begin
        voice_pend[it.voice] = {it.end_index, 2'b00};
        voice_pend_ok[it.voice] = 1'b1;
      end
      REQ_INC: voice_inc[it.voice] = it.step_inc;
      REQ_TRIGGER: begin
        voice_big[it.voice] = it.shift_big;
        voice_small[it.voice] = it.shift_small;
        voice_pos[it.voice] = {1'b0, voice_start[it.voice]};
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  // Sample address a voice will read on the next tick, if it plays.
  function automatic bit voice_reads(input int i, output logic [13:0] addr);
    logic [15:0] last;
    last = (voice_pend_ok[i] && voice_pos[i] == {1'b0, voice_start[i]}) ?
           voice_pend[i] : voice_end[i];
    addr = voice_pos[i][15:2];
    return voice_pos[i] <= {1'b0, last};
  endfunction

  function automatic in_item_t with_type(input logic [2:0] req);
    logic [95:0] r;
    in_item_t it;
    r = {$urandom, $urandom, $urandom};
    it = r[65:0];
    it.req_type = req;
    return it;
  endfunction

  function automatic void row(input logic [2:0] req, input int v, input int widx,
                              input int wbyte, input int s, input int e, input int inc,
                              input int sb, input int ss, input bit typed,
                              input int lvl, input int mask);
    script_row_t r;
    r.it = '0;
    r.it.req_type = req;
    r.it.voice = 3'(v);
    r.it.wave_index = 14'(widx);
    r.it.wave_byte = 8'(wbyte);
    r.it.start_index = 14'(s);
    r.it.end_index = 14'(e);
    r.it.step_inc = 4'(inc);
    r.it.shift_big = 3'(sb);
    r.it.shift_small = 3'(ss);
    r.typed = typed;
    r.want.pwm_level = 8'(lvl);
    r.want.active_mask = 8'(mask);
    script.push_back(r);
  endfunction

  task automatic transfer(input in_item_t it);
    while (!calm && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_items++;
  endtask

  // Loads any sample a playing voice is about to read before the tick goes out.
  task automatic send(input in_item_t it, input bit typed, input out_item_t want);
    in_item_t fill;
    out_item_t res;
    logic [13:0] a;
    int i;
    if (it.req_type == REQ_TICK) begin
      for (i = 0; i < VOICES; i++) begin
        if (voice_reads(i, a) && !wave_known[a]) begin
          fill = with_type(REQ_LOAD);
          fill.wave_index = a;
          transfer(fill);
          void'(model_step(fill, res));
          n_fixups++;
        end
      end
    end
    transfer(it);
    if (model_step(it, res)) begin
      mix_expected.push_back(typed ? want : res);
      n_ticks++;
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (mix_expected.size() != 0) @(posedge clk);
  endtask

  task automatic play_phrase();
    in_item_t it;
    logic [2:0] v;
    int s;
    int e;
    v = 3'($urandom_range(0, 7));
    s = ($urandom_range(99) < 80) ? $urandom_range(0, 63) : $urandom_range(0, 16383);
    e = s + (($urandom_range(99) < 70) ? $urandom_range(0, 8) : $urandom_range(0, 48));
    if ($urandom_range(99) < 4) e = $urandom_range(0, 16383);
    if (e > 16383) e = 16383;
    it = with_type(REQ_REGION);
    it.voice = v;
    it.start_index = 14'(s);
    it.end_index = 14'(e);
    send(it, 1'b0, '0);
    if ($urandom_range(99) < 30) begin
      it = with_type(REQ_PEND_END);
      it.voice = v;
      e = s + $urandom_range(0, 16);
      if ($urandom_range(99) < 5) e = $urandom_range(0, 16383);
      it.end_index = (e > 16383) ? 14'd16383 : 14'(e);
      send(it, 1'b0, '0);
    end
    if ($urandom_range(99) < 40) begin
      it = with_type(REQ_INC);
      it.voice = v;
      it.step_inc = ($urandom_range(99) < 6) ? 4'd0 : 4'($urandom_range(1, 15));
      send(it, 1'b0, '0);
    end
    it = with_type(REQ_TRIGGER);
    it.voice = v;
    send(it, 1'b0, '0);
    repeat ($urandom_range(1, 6)) send(with_type(REQ_TICK), 1'b0, '0);
  endtask

  initial begin
    in_item_t it;
    int i;
    int r;
    bit squeezed;
    for (i = 0; i < VOICES; i++) begin
      voice_pos[i] = '1;
      voice_start[i] = '0;
      voice_end[i] = '0;
      voice_pend[i] = '0;
      voice_pend_ok[i] = 1'b0;
      voice_inc[i] = 4'd4;
      voice_big[i] = '0;
      voice_small[i] = '0;
    end
    for (i = 0; i < WAVE_DEPTH; i++) begin
      wave_mem[i] = '0;
      wave_known[i] = 1'b0;
    end

    //  req           v  widx   byte  start  end   inc sb ss typed lvl  mask
    row(REQ_TICK,     0, 0,     0,    0,     0,    0,  0, 0, 1,    128, 8'h00);
    row(REQ_LOAD,     0, 0,     127,  0,     0,    0,  0, 0, 0,    0,   0);
    row(REQ_LOAD,     0, 16383, -128, 0,     0,    0,  0, 0, 0,    0,   0);
    row(REQ_LOAD,     0, 1,     -1,   0,     0,    0,  0, 0, 0,    0,   0);
    row(REQ_LOAD,     0, 2,     64,   0,     0,    0,  0, 0, 0,    0,   0);
    row(REQ_TRIGGER,  0, 0,     0,    0,     0,    0,  0, 0, 0,    0,   0);
    row(REQ_TICK,     0, 0,     0,    0,     0,    0,  0, 0, 1,    255, 8'h01);
    row(REQ_TICK,     0, 0,     0,    0,     0,    0,  0, 0, 1,    128, 8'h00);
    row(REQ_REGION,   7, 0,     0,    16383, 16383, 0, 0, 0, 0,    0,   0);
    row(REQ_TRIGGER,  7, 0,     0,    0,     0,    0,  0, 0, 0,    0,   0);
    row(REQ_TICK,     0, 0,     0,    0,     0,    0,  0, 0, 1,    0,   8'h80);
    row(REQ_TRIGGER,  7, 0,     0,    0,     0,    0,  7, 7, 0,    0,   0);
    row(REQ_TICK,     0, 0,     0,    0,     0,    0,  0, 0, 1,    126, 8'h80);
    // end below start, pending end taken over at the first tick
    row(REQ_REGION,   1, 0,     0,    1,     0,    0,  0, 0, 0,    0,   0);
    row(REQ_PEND_END, 1, 0,     0,    0,     2,    0,  0, 0, 0,    0,   0);
    row(REQ_INC,      1, 0,     0,    0,     0,    15, 0, 0, 0,    0,   0);
    row(REQ_TRIGGER,  1, 0,     0,    0,     0,    0,  1, 2, 0,    0,   0);
    row(REQ_TICK,     0, 0,     0,    0,     0,    0,  0, 0, 0,    0,   0);
    row(REQ_TICK,     0, 0,     0,    0,     0,    0,  0, 0, 0,    0,   0);
    // zero increment holds the voice on its first sample
    row(REQ_INC,      2, 0,     0,    0,     0,    0,  0, 0, 0,    0,   0);
    row(REQ_TRIGGER,  2, 0,     0,    0,     0,    0,  3, 5, 0,    0,   0);
    row(REQ_TICK,     0, 0,     0,    0,     0,    0,  0, 0, 0,    0,   0);
    row(REQ_TICK,     0, 0,     0,    0,     0,    0,  0, 0, 0,    0,   0);
    row(REQ_SPARE_A,  5, 9999,  -7,   3,     9,    6,  1, 4, 0,    0,   0);
    row(REQ_SPARE_B,  3, 1234,  55,   16383, 16383, 15, 7, 7, 0,   0,   0);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (script[k]) begin
      it = script[k].it;
      if (it.req_type == REQ_SPARE_A || it.req_type == REQ_SPARE_B) it = with_type(it.req_type);
      send(it, script[k].typed, script[k].want);
    end
    drain();

    squeezed = 1'b0;
    while (n_items < RANDOM_ITEMS + script.size()) begin
      calm = (n_items > 400 && n_items < 560);
      if (!squeezed && n_items > 700) begin
        drain();
        squeezed = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 55) begin
        play_phrase();
      end else if (r < 75) begin
        repeat ($urandom_range(1, 4)) send(with_type(REQ_TICK), 1'b0, '0);
      end else if (r < 88) begin
        it = with_type(REQ_LOAD);
        if ($urandom_range(1)) it.wave_index = 14'($urandom_range(0, 127));
        send(it, 1'b0, '0);
      end else if (r < 94) begin
        send(with_type(3'($urandom_range(REQ_REGION, REQ_TRIGGER))), 1'b0, '0);
      end else begin
        send(with_type($urandom_range(1) ? REQ_SPARE_A : REQ_SPARE_B), 1'b0, '0);
      end
    end
    calm = 1'b0;
    drain();
    repeat (SETTLE) @(posedge clk);

    $display("%0d transfers in (%0d sample fills), %0d ticks, %0d levels checked",
             n_items, n_fixups, n_ticks, n_checked);
    $display("directed edges, pending ends, zero step, spare request types, random phrases");
    if (n_bad == 0) begin
      $display("drum_sample_voice_mixer_test: clean");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("drum_sample_voice_mixer_test: errors");
    end
    $finish;
  end

endmodule
